// ===== hw/rtl/lhc_pkg.sv =====
// Shared types and constants for the latency histogram counter.
// Holds the bound tables, field widths, codes and the sequencer state type.
// No dependencies.
package lhc_pkg;

  localparam int LAT_W      = 40;
  localparam int IN_DATA_W  = 48;
  localparam int IDX_OUT_W  = 4;
  localparam int OUT_CNT_W  = 48;
  localparam int TOTAL_W    = 64;
  localparam int OUT_PAD_W  = 4;
  localparam int OUT_DATA_W = IDX_OUT_W + 3 * OUT_CNT_W + TOTAL_W + OUT_PAD_W;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam int TABLE_LEN = 12;
  localparam int BOUND_W   = 24;

  localparam logic [BOUND_W-1:0] CMD_BOUNDS [TABLE_LEN] = '{
    24'd100, 24'd250, 24'd500, 24'd1000, 24'd2500, 24'd5000,
    24'd10000, 24'd25000, 24'd50000, 24'd100000, 24'd500000, 24'd1000000
  };

  localparam logic [BOUND_W-1:0] DB_BOUNDS [TABLE_LEN] = '{
    24'd1000, 24'd2500, 24'd5000, 24'd10000, 24'd25000, 24'd50000,
    24'd100000, 24'd250000, 24'd500000, 24'd1000000, 24'd5000000, 24'd10000000
  };

  localparam logic KIND_OBSERVE  = 1'b0;
  localparam logic KIND_SNAPSHOT = 1'b1;

  localparam logic BOUNDS_CMD = 1'b0;
  localparam logic BOUNDS_DB  = 1'b1;

  localparam logic [APB_AW-3:0] REG_BOUND_SET = '0;

  typedef enum logic {
    ST_IDLE,
    ST_SNAP
  } lhc_state_t;

endpackage

// ===== hw/rtl/latency_histogram_counter_top.sv =====
// Top level of the latency histogram counter: stream ports, APB register,
// bucket RAM with read-modify-write and the snapshot sequencer.
// Depends on lhc_pkg, lhc_ram and lhc_bucket_sel.
//
//   Channel   Direction  Carries
//   s_*       in         observe (latency, slow flag) or snapshot request
//   m_*       out        one histogram row per transfer, tlast on the final row
//   APB       in/out     bound_set register at byte address 0
//
// Observations are taken one per cycle while no snapshot runs; the bucket RAM is read at the
// transfer and written back in the next cycle, with forwarding between back-to-back updates.
// A snapshot holds off the input until its final row is loaded: a RAM read of the first
// bucket, then one row per cycle from the RAM read port while the output is not stalled.
// Reset clears all counters; bucket entries carry valid bits, so no clearing pass.
// An output stall re-reads the current row and resumes without loss.
module latency_histogram_counter_top #(
  parameter int NUM_BOUNDS  = 12,
  parameter int COUNT_WIDTH = 48
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // latency_us [39:0], slow [40], zero fill [47:41]
  input  logic [lhc_pkg::IN_DATA_W-1:0]    s_tdata,
  // kind [0]
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // bucket_index [3:0], cumulative_count [51:4], total_micros [115:52],
  // event_count [163:116], slow_count [211:164], zero fill [215:212]
  output logic [lhc_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                             m_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lhc_pkg::APB_AW-1:0]       paddr,
  input  logic [lhc_pkg::APB_DW-1:0]       pwdata,
  output logic [lhc_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);
  import lhc_pkg::*;

  localparam int NBK = NUM_BOUNDS + 1;
  localparam int BW  = $clog2(NBK);
  localparam int CW  = COUNT_WIDTH;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  lhc_state_t state, state_next;

  logic               bound_set;
  logic [TOTAL_W-1:0] total;
  logic [CW-1:0]      evt_cnt;
  logic [CW-1:0]      slow_cnt;

  logic               in_acc, obs_acc, snap_acc;
  logic [LAT_W-1:0]   s_lat;
  logic               s_slow;
  logic [BW-1:0]      bucket;

  logic               obs_v;
  logic [BW-1:0]      obs_b;
  logic               wr_v_q;
  logic [BW-1:0]      wr_addr_q;
  logic [CW-1:0]      wr_data_q;
  logic [NBK-1:0]     vld;
  logic [CW-1:0]      cur, inc;

  logic [BW-1:0]      raddr;
  logic [CW-1:0]      rdata;

  logic [BW-1:0]      snap_idx;
  logic               pend;
  logic [CW-1:0]      running;
  logic [CW-1:0]      snap_val;
  logic [CW:0]        sum_w;
  logic [CW-1:0]      sum_sat;
  logic               snap_last;
  logic               load;

  logic [BW-1:0]      out_idx;
  logic [CW-1:0]      out_cum;
  logic [TOTAL_W-1:0] out_total;
  logic [CW-1:0]      out_evt;
  logic [CW-1:0]      out_slow;
  logic               out_last;

  logic [BW+IDX_OUT_W-1:0] idx_ext;
  logic [CW+OUT_CNT_W-1:0] cum_ext, evt_ext, slow_ext;

  logic                cfg_wr;
  logic [APB_AW-3:0]   reg_idx;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid & s_tready;
  assign obs_acc  = in_acc && (s_tuser == KIND_OBSERVE);
  assign snap_acc = in_acc && (s_tuser == KIND_SNAPSHOT);
  assign s_lat    = s_tdata[LAT_W-1:0];
  assign s_slow   = s_tdata[LAT_W];

  lhc_bucket_sel #(
    .NUM_BOUNDS(NUM_BOUNDS)
  ) u_bucket_sel (
    .latency_us(s_lat),
    .bound_set (bound_set),
    .bucket    (bucket)
  );

  lhc_ram #(
    .WIDTH(CW),
    .DEPTH(NBK)
  ) u_ram (
    .clk  (clk),
    .we   (obs_v),
    .waddr(obs_b),
    .wdata(inc),
    .raddr(raddr),
    .rdata(rdata)
  );

  // The entry written in the previous cycle is not yet visible at the read port.
  assign cur = (wr_v_q && (wr_addr_q == obs_b)) ? wr_data_q :
               (vld[obs_b] ? rdata : '0);
  assign inc = (cur == CMAX) ? cur : cur + 1'b1;

  assign snap_val  = vld[snap_idx] ? rdata : '0;
  assign sum_w     = {1'b0, running} + {1'b0, snap_val};
  assign sum_sat   = sum_w[CW] ? CMAX : sum_w[CW-1:0];
  assign snap_last = (snap_idx == BW'(NUM_BOUNDS));
  assign load      = (state == ST_SNAP) && pend && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    raddr      = bucket;
    case (state)
      ST_IDLE: begin
        raddr = bucket;
        if (snap_acc) begin
          state_next = ST_SNAP;
        end
      end
      ST_SNAP: begin
        raddr = (load && !snap_last) ? snap_idx + 1'b1 : snap_idx;
        if (load && snap_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obs_v    <= 1'b0;
      wr_v_q   <= 1'b0;
      vld      <= '0;
      total    <= '0;
      evt_cnt  <= '0;
      slow_cnt <= '0;
    end else begin
      obs_v  <= obs_acc;
      wr_v_q <= obs_v;
      if (obs_v) begin
        vld[obs_b] <= 1'b1;
      end
      if (obs_acc) begin
        total <= total + {{(TOTAL_W - LAT_W){1'b0}}, s_lat};
        if (evt_cnt != CMAX) begin
          evt_cnt <= evt_cnt + 1'b1;
        end
        if (s_slow && (slow_cnt != CMAX)) begin
          slow_cnt <= slow_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    obs_b     <= bucket;
    wr_addr_q <= obs_b;
    wr_data_q <= inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_idx <= '0;
      pend     <= 1'b0;
      running  <= '0;
    end else if (snap_acc) begin
      snap_idx <= '0;
      pend     <= 1'b0;
      running  <= '0;
    end else if (state == ST_SNAP) begin
      pend <= !(load && snap_last);
      if (load) begin
        snap_idx <= snap_idx + 1'b1;
        running  <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_idx   <= snap_idx;
      out_cum   <= sum_sat;
      out_total <= total;
      out_evt   <= evt_cnt;
      out_slow  <= slow_cnt;
      out_last  <= snap_last;
    end
  end

  assign idx_ext  = {{IDX_OUT_W{1'b0}}, out_idx};
  assign cum_ext  = {{OUT_CNT_W{1'b0}}, out_cum};
  assign evt_ext  = {{OUT_CNT_W{1'b0}}, out_evt};
  assign slow_ext = {{OUT_CNT_W{1'b0}}, out_slow};

  assign m_tdata = {{OUT_PAD_W{1'b0}}, slow_ext[OUT_CNT_W-1:0], evt_ext[OUT_CNT_W-1:0],
                    out_total, cum_ext[OUT_CNT_W-1:0], idx_ext[IDX_OUT_W-1:0]};
  assign m_tlast = out_last;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = (reg_idx == REG_BOUND_SET) ? {{(APB_DW - 1){1'b0}}, bound_set} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_set <= BOUNDS_CMD;
    end else if (cfg_wr && (reg_idx == REG_BOUND_SET)) begin
      bound_set <= pwdata[0];
    end
  end

  a_last_on_final_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_last == (out_idx == BW'(NUM_BOUNDS))))
    else $error("tlast does not match the final bucket row");

  a_no_update_in_snapshot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SNAP) |-> !obs_v)
    else $error("bucket update pending while a snapshot reads the RAM");

  a_snapshot_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    snap_acc |=> ((state == ST_SNAP) && (snap_idx == '0) && (running == '0)))
    else $error("snapshot did not start at the first bucket");

  a_row_advance: assert property (@(posedge clk) disable iff (rst)
    (load && !snap_last) |=> (snap_idx == BW'($past(snap_idx) + 1'b1)))
    else $error("snapshot row index did not advance by one");

endmodule

// ===== hw/rtl/lhc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// A read at the same edge as a write to that address returns the old contents.
// No dependencies.
module lhc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lhc_bucket_sel.sv =====
// Bucket selection: finds the first bound that a latency does not exceed.
// Depends on lhc_pkg for the two bound tables.
module lhc_bucket_sel #(
  parameter int NUM_BOUNDS = 12
) (
  input  logic [lhc_pkg::LAT_W-1:0]         latency_us,
  input  logic                              bound_set,
  output logic [$clog2(NUM_BOUNDS+1)-1:0]   bucket
);
  import lhc_pkg::*;

  localparam int BW    = $clog2(NUM_BOUNDS + 1);
  localparam int TAB_N = (NUM_BOUNDS < TABLE_LEN) ? NUM_BOUNDS : TABLE_LEN;

  always_comb begin
    logic [BOUND_W-1:0] bnd;
    bucket = BW'(NUM_BOUNDS);
    bnd    = '0;
    for (int i = TAB_N - 1; i >= 0; i--) begin
      bnd = (bound_set == BOUNDS_DB) ? DB_BOUNDS[i] : CMD_BOUNDS[i];
      if (latency_us <= {{(LAT_W - BOUND_W){1'b0}}, bnd}) begin
        bucket = BW'(i);
      end
    end
  end

endmodule
